// File: sv/sac_pkg.sv
// sac_pkg: shared constants, count codes and the close-event control word
// of the strip add-back clusterer
// no dependencies
package sac_pkg;

    localparam int STRIP_BITS  = 7;
    localparam int WINDOW_BITS = 20;
    localparam int COUNT_BITS  = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(100);

    // hit count codes of a group, saturating at crowd
    localparam logic [COUNT_BITS-1:0] CNT_NONE   = 2'd0;
    localparam logic [COUNT_BITS-1:0] CNT_SINGLE = 2'd1;
    localparam logic [COUNT_BITS-1:0] CNT_PAIR   = 2'd2;
    localparam logic [COUNT_BITS-1:0] CNT_CROWD  = 2'd3;

    // which groups a word closes: a = group open before the word, b = group after it
    typedef struct packed {
        logic                  a_close;
        logic [COUNT_BITS-1:0] a_count;
        logic                  b_close;
        logic [COUNT_BITS-1:0] b_count;
    } close_ctl_t;

endpackage

// File: sv/sac_hit_if.sv
// sac_hit_if: input channel of the clusterer, one strip hit per word
// depends on sac_pkg
interface sac_hit_if #(
    parameter int TIME_BITS   = 48,
    parameter int ENERGY_BITS = 16
);
    import sac_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [TIME_BITS-1:0]   hit_time;
    logic [STRIP_BITS-1:0]  hit_strip;
    logic [ENERGY_BITS-1:0] hit_energy;
    logic                   end_of_stream;

    modport source (output valid, hit_time, hit_strip, hit_energy, end_of_stream,
                    input ready);
    modport sink   (input valid, hit_time, hit_strip, hit_energy, end_of_stream,
                    output ready);
endinterface

// File: sv/sac_result_if.sv
// sac_result_if: output channel of the clusterer, one emitted hit per word
// depends on sac_pkg
interface sac_result_if #(
    parameter int TIME_BITS   = 48,
    parameter int ENERGY_BITS = 16
);
    import sac_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [TIME_BITS-1:0]   out_time;
    logic [STRIP_BITS-1:0]  out_strip;
    logic [ENERGY_BITS:0]   out_energy;
    logic                   merged;
    logic                   last_of_run;

    modport source (output valid, out_time, out_strip, out_energy, merged, last_of_run,
                    input ready);
    modport sink   (input valid, out_time, out_strip, out_energy, merged, last_of_run,
                    output ready);
endinterface

// File: sv/sac_cfg_if.sv
// sac_cfg_if: configuration write channel carrying the coincidence window
// depends on sac_pkg
interface sac_cfg_if;
    import sac_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [WINDOW_BITS-1:0] coincidence_window;

    modport source (output valid, coincidence_window, input ready);
    modport sink   (input valid, coincidence_window, output ready);
endinterface

// File: sv/sac_front.sv
// sac_front: takes hit words, tracks the open group and its first two hits,
// and queues a close event for every word that closes one or two groups
// depends on sac_pkg, sac_hit_if, sac_cfg_if
module sac_front #(
    parameter int TIME_BITS   = 48,
    parameter int ENERGY_BITS = 16,
    localparam int HIT_W      = TIME_BITS + sac_pkg::STRIP_BITS + ENERGY_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    sac_hit_if.sink             hits,
    sac_cfg_if.sink             cfg,
    input  logic                q_ready,
    output logic                push,
    output sac_pkg::close_ctl_t push_ctl,
    output logic [4*HIT_W-1:0]  push_hits
);
    import sac_pkg::*;

    logic [WINDOW_BITS-1:0] win_reg;
    logic                   open_reg, open_next;
    logic [TIME_BITS-1:0]   start_reg, start_next;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [HIT_W-1:0]       h0_reg, h1_reg;

    logic                   acc;
    logic [HIT_W-1:0]       hit;
    logic [TIME_BITS-1:0]   diff;
    logic [TIME_BITS-1:0]   span;
    logic                   close_old;
    logic                   fresh;
    logic [COUNT_BITS-1:0]  g_cnt;
    logic [HIT_W-1:0]       g_h0, g_h1;

    assign cfg.ready  = 1'b1;
    assign hits.ready = q_ready;
    assign acc        = hits.valid && q_ready;
    assign hit        = {hits.hit_time, hits.hit_strip, hits.hit_energy};

    // group span is twice the window
    assign diff      = hits.hit_time - start_reg;
    assign span      = {{(TIME_BITS-WINDOW_BITS-1){1'b0}}, win_reg, 1'b0};
    assign close_old = open_reg && (hits.hit_time >= start_reg) && (diff > span);
    assign fresh     = close_old || !open_reg;

    always_comb
    begin
        if (fresh)
        begin
            g_cnt = CNT_SINGLE;
            g_h0  = hit;
            g_h1  = h1_reg;
        end
        else
        begin
            g_cnt = (cnt_reg == CNT_CROWD) ? CNT_CROWD : cnt_reg + COUNT_BITS'(1);
            g_h0  = h0_reg;
            g_h1  = (cnt_reg == CNT_SINGLE) ? hit : h1_reg;
        end

        if (hits.end_of_stream)
        begin
            open_next = 1'b0;
            cnt_next  = CNT_NONE;
        end
        else
        begin
            open_next = 1'b1;
            cnt_next  = g_cnt;
        end
        start_next = fresh ? hits.hit_time : start_reg;
    end

    assign push             = acc && (close_old || hits.end_of_stream);
    assign push_ctl.a_close = close_old;
    assign push_ctl.a_count = cnt_reg;
    assign push_ctl.b_close = hits.end_of_stream;
    assign push_ctl.b_count = g_cnt;
    assign push_hits        = {h0_reg, h1_reg, g_h0, g_h1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= WINDOW_RESET;
            open_reg  <= 1'b0;
            start_reg <= '0;
            cnt_reg   <= CNT_NONE;
        end
        else
        begin
            if (cfg.valid)
            begin
                win_reg <= cfg.coincidence_window;
            end
            if (acc)
            begin
                open_reg  <= open_next;
                start_reg <= start_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            h0_reg <= g_h0;
            h1_reg <= g_h1;
        end
    end

endmodule

// File: sv/sac_queue.sv
// sac_queue: small register fifo between the front and back parts,
// head word is visible without a read cycle
// no dependencies
module sac_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              push_ready,
    input  logic              pop,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_data
);
    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_reg, rd_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = mem_reg[rd_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(DEPTH-1)) ? '0 : rd_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

// File: sv/sac_back.sv
// sac_back: applies the add-back rules to queued close events and drives
// the result channel from an output register
// depends on sac_pkg, sac_result_if
module sac_back #(
    parameter int TIME_BITS   = 48,
    parameter int ENERGY_BITS = 16,
    localparam int HIT_W      = TIME_BITS + sac_pkg::STRIP_BITS + ENERGY_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  sac_pkg::close_ctl_t head_ctl,
    input  logic [4*HIT_W-1:0]  head_hits,
    output logic                pop,
    sac_result_if.source        results
);
    import sac_pkg::*;

    typedef struct packed {
        logic                   ok;
        logic [TIME_BITS-1:0]   t;
        logic [STRIP_BITS-1:0]  s;
        logic [ENERGY_BITS:0]   e;
        logic                   merged;
    } res_t;

    function automatic res_t eval_group(input logic [COUNT_BITS-1:0] cnt,
                                        input logic [HIT_W-1:0] h0,
                                        input logic [HIT_W-1:0] h1);
        res_t                   r;
        logic [STRIP_BITS:0]    s0, s1;
        logic [ENERGY_BITS-1:0] e0, e1;
        logic                   adj;
        logic [HIT_W-1:0]       pick;
        begin
            s0   = {1'b0, h0[ENERGY_BITS +: STRIP_BITS]};
            s1   = {1'b0, h1[ENERGY_BITS +: STRIP_BITS]};
            e0   = h0[ENERGY_BITS-1:0];
            e1   = h1[ENERGY_BITS-1:0];
            adj  = (s0 + (STRIP_BITS+1)'(1) == s1) || (s1 + (STRIP_BITS+1)'(1) == s0);
            // on an energy tie the second hit wins
            pick = (e0 > e1) ? h0 : h1;
            r    = '0;
            if (cnt == CNT_SINGLE)
            begin
                r.ok = 1'b1;
                r.t  = h0[HIT_W-1 -: TIME_BITS];
                r.s  = h0[ENERGY_BITS +: STRIP_BITS];
                r.e  = {1'b0, e0};
            end
            else if (cnt == CNT_PAIR)
            begin
                r.ok     = adj;
                r.t      = pick[HIT_W-1 -: TIME_BITS];
                r.s      = pick[ENERGY_BITS +: STRIP_BITS];
                r.e      = {1'b0, e0} + {1'b0, e1};
                r.merged = 1'b1;
            end
            eval_group = r;
        end
    endfunction

    res_t ra, rb;
    logic a_ok, b_ok, load_ok;
    logic phase_reg, phase_next;
    logic out_valid_reg, out_valid_next;
    logic load;
    res_t load_res;
    logic load_last;
    res_t out_reg;
    logic out_last_reg;

    assign ra = eval_group(head_ctl.a_count, head_hits[4*HIT_W-1 -: HIT_W],
                           head_hits[3*HIT_W-1 -: HIT_W]);
    assign rb = eval_group(head_ctl.b_count, head_hits[2*HIT_W-1 -: HIT_W],
                           head_hits[HIT_W-1:0]);

    // old group's result goes first unless it was already sent
    assign a_ok    = head_ctl.a_close && ra.ok && !phase_reg;
    assign b_ok    = head_ctl.b_close && rb.ok;
    assign load_ok = !out_valid_reg || results.ready;

    always_comb
    begin
        pop        = 1'b0;
        load       = 1'b0;
        load_res   = rb;
        load_last  = 1'b1;
        phase_next = phase_reg;
        if (head_valid && load_ok)
        begin
            if (a_ok)
            begin
                load      = 1'b1;
                load_res  = ra;
                load_last = !b_ok;
                if (b_ok)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    pop = 1'b1;
                end
            end
            else
            begin
                load       = b_ok;
                pop        = 1'b1;
                phase_next = 1'b0;
            end
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg      <= load_res;
            out_last_reg <= load_last;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.out_time    = out_reg.t;
    assign results.out_strip   = out_reg.s;
    assign results.out_energy  = out_reg.e;
    assign results.merged      = out_reg.merged;
    assign results.last_of_run = out_last_reg;

endmodule

// File: sv/strip_addback_clusterer_unit.sv
// strip_addback_clusterer_unit: top level, front classifier, event queue
// and add-back back end
// depends on sac_pkg, sac_hit_if, sac_result_if, sac_cfg_if, sac_front, sac_queue, sac_back
//
// Usage:
//   hits    - time-sorted strip hit words (time, strip, energy, end_of_stream)
//   results - emitted hits: single hits as they are, neighbor pairs summed,
//             last_of_run marks the last result caused by one hit word
//   cfg     - write of the coincidence window, taken in the cycle it is valid;
//             write it only while no results are pending
// Throughput: one hit word per cycle while the event queue has room. A word
//   that closes two groups can yield two results; the four-word event queue
//   between the front and back parts absorbs that and short output stalls.
// Path: the event of a closing hit word is written into the queue, and its result
//   is loaded from the queue head into the output register; a second result follows.
// Stalls: a stalled results port holds the output register, the queue fills
//   and hits.ready drops once it is full.
// Reset: window goes to 100, no group is open, queue and output are empty.
module strip_addback_clusterer_unit #(
    parameter int TIME_BITS   = 48,
    parameter int ENERGY_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    sac_hit_if.sink      hits,
    sac_result_if.source results,
    sac_cfg_if.sink      cfg
);
    import sac_pkg::*;

    localparam int HIT_W  = TIME_BITS + STRIP_BITS + ENERGY_BITS;
    localparam int CTL_W  = $bits(close_ctl_t);
    localparam int DATA_W = CTL_W + 4*HIT_W;

    logic               push, q_ready, pop, head_valid;
    close_ctl_t         push_ctl, head_ctl;
    logic [4*HIT_W-1:0] push_hits, head_hits;
    logic [DATA_W-1:0]  head_data;

    sac_front #(
        .TIME_BITS   (TIME_BITS),
        .ENERGY_BITS (ENERGY_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hits      (hits),
        .cfg       (cfg),
        .q_ready   (q_ready),
        .push      (push),
        .push_ctl  (push_ctl),
        .push_hits (push_hits)
    );

    sac_queue #(
        .DATA_W (DATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_ctl, push_hits}),
        .push_ready (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    assign head_ctl  = head_data[DATA_W-1 -: CTL_W];
    assign head_hits = head_data[4*HIT_W-1:0];

    sac_back #(
        .TIME_BITS   (TIME_BITS),
        .ENERGY_BITS (ENERGY_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_ctl   (head_ctl),
        .head_hits  (head_hits),
        .pop        (pop),
        .results    (results)
    );

endmodule
